FILE: src/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared types, constants and helper functions for the mouse packet cursor
// tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;

  localparam int DATA_W     = 8;
  localparam int CURSOR_X_W = 7;
  localparam int CURSOR_Y_W = 5;
  localparam int TARGET_W   = 2;
  localparam int DELTA_W    = 8;

  localparam int DIV3_RECIP = 171;
  localparam int DIV3_SHIFT = 9;

  localparam int HDR_LEFT   = 0;
  localparam int HDR_ONE    = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;
  localparam int HDR_XOVF   = 6;
  localparam int HDR_YOVF   = 7;

  localparam int ROW_LO     = 1;
  localparam int ROW_HI     = 3;
  localparam int TERM0_LO   = 19;
  localparam int TERM0_HI   = 23;
  localparam int TERM1_LO   = 25;
  localparam int TERM1_HI   = 29;
  localparam int TERM2_LO   = 31;
  localparam int TERM2_HI   = 35;

  typedef enum logic [TARGET_W-1:0] {
    TERM_0 = 2'd0,
    TERM_1 = 2'd1,
    TERM_2 = 2'd2
  } term_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_t;

  // Sign-extends a delta to nine bits and divides it by three, truncating
  // towards zero. The magnitude is at most 256, so a reciprocal multiply is
  // exact.
  function automatic logic signed [DELTA_W-1:0] div3_delta(input logic sign,
                                                           input logic [DATA_W-1:0] low);
    logic [DATA_W:0]     mag;
    logic [2*DATA_W:0]   prod;
    logic [DELTA_W-1:0]  quot;
    mag  = sign ? ((DATA_W+1)'(1 << DATA_W) - {1'b0, low}) : {1'b0, low};
    prod = (2*DATA_W+1)'(mag) * (2*DATA_W+1)'(DIV3_RECIP);
    quot = DELTA_W'(prod >> DIV3_SHIFT);
    return sign ? -quot : quot;
  endfunction

endpackage

FILE: src/mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker
// Decodes three-byte PS/2 mouse packets and tracks a clamped text cursor.
// ----------------------------------------------------------------------------
// Bytes from the mouse port arrive on the in_ channel, one per transaction.
// A header byte with an overflow bit set or bit 3 clear is dropped and the
// next byte is tried as a header. The third byte of a packet produces one
// transaction on the out_ channel with the new and previous cursor position,
// a moved flag, the left button and a terminal-switch request.
// Each byte passes through an input register and a single stage of logic
// into the result register. One byte is accepted every cycle unless the
// input stalls, as described below.
// When the receiver stalls, a waiting result is held; header and X delta
// bytes keep flowing, and the input stalls only once a byte that completes
// a packet finds the result register still occupied.
// Reset clears the packet phase, the cursor position to column 0, row 0, and
// both channels' valid state.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_tracker #(
  parameter int SCREEN_COLS = mpct_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = mpct_pkg::SCREEN_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mpct_pkg::DATA_W-1:0]     in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mpct_pkg::CURSOR_X_W-1:0] out_cursor_x,
  output logic [mpct_pkg::CURSOR_Y_W-1:0] out_cursor_y,
  output logic [mpct_pkg::CURSOR_X_W-1:0] out_prev_x,
  output logic [mpct_pkg::CURSOR_Y_W-1:0] out_prev_y,
  output logic                            out_moved,
  output logic                            out_left_pressed,
  output logic                            out_switch_request,
  output logic [mpct_pkg::TARGET_W-1:0]   out_switch_target
);
  import mpct_pkg::*;

  localparam int PXW  = $clog2(SCREEN_COLS);
  localparam int PYW  = $clog2(SCREEN_ROWS);
  localparam int XS_W = ((PXW > DELTA_W) ? PXW : DELTA_W) + 2;
  localparam int YS_W = ((PYW > DELTA_W) ? PYW : DELTA_W) + 2;
  localparam logic signed [XS_W-1:0] X_MAX = XS_W'(SCREEN_COLS - 1);
  localparam logic signed [YS_W-1:0] Y_MAX = YS_W'(SCREEN_ROWS - 1);

  logic                     s1_valid_r;
  logic [DATA_W-1:0]        s1_byte_r;
  phase_t                   phase_r, phase_nxt;
  logic [DATA_W-1:0]        header_r, header_nxt;
  logic [DATA_W-1:0]        dx_r, dx_nxt;
  logic [PXW-1:0]           pos_x_r, pos_x_nxt;
  logic [PYW-1:0]           pos_y_r, pos_y_nxt;

  logic                     out_valid_r;
  logic [CURSOR_X_W-1:0]    cur_x_r, prev_x_r;
  logic [CURSOR_Y_W-1:0]    cur_y_r, prev_y_r;
  logic                     moved_r, left_r, req_r;
  term_t                    tgt_r;

  logic                     hdr_ok;
  logic                     s1_result;
  logic                     s1_adv;
  logic                     out_free;
  logic signed [DELTA_W-1:0] dx_q, dy_q;
  logic signed [XS_W-1:0]   x_sum;
  logic signed [YS_W-1:0]   y_sum;
  logic [PXW-1:0]           new_x;
  logic [PYW-1:0]           new_y;
  logic                     row_hit;
  logic                     req_c;
  term_t                    tgt_c;
  logic [XS_W-1:0]          new_x_ext, old_x_ext;
  logic [YS_W-1:0]          new_y_ext, old_y_ext;

  assign hdr_ok    = !s1_byte_r[HDR_XOVF] && !s1_byte_r[HDR_YOVF] && s1_byte_r[HDR_ONE];
  assign s1_result = s1_valid_r && (phase_r == PH_DY);
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && (!s1_result || out_free);
  assign in_stall  = s1_valid_r && !s1_adv;

  always_comb begin
    phase_nxt = phase_r;
    if (s1_adv) begin
      unique case (phase_r)
        PH_DX:   phase_nxt = PH_DY;
        PH_DY:   phase_nxt = PH_HEADER;
        default: phase_nxt = hdr_ok ? PH_DX : PH_HEADER;
      endcase
    end
  end

  always_comb begin
    dx_q      = div3_delta(header_r[HDR_XSIGN], dx_r);
    dy_q      = div3_delta(header_r[HDR_YSIGN], s1_byte_r);
    x_sum     = XS_W'(pos_x_r) + XS_W'(dx_q);
    y_sum     = YS_W'(pos_y_r) - YS_W'(dy_q);
    if (x_sum < 0) begin
      new_x = '0;
    end else if (x_sum > X_MAX) begin
      new_x = PXW'(X_MAX);
    end else begin
      new_x = PXW'(x_sum);
    end
    if (y_sum < 0) begin
      new_y = '0;
    end else if (y_sum > Y_MAX) begin
      new_y = PYW'(Y_MAX);
    end else begin
      new_y = PYW'(y_sum);
    end
    row_hit = header_r[HDR_LEFT] && (new_y >= PYW'(ROW_LO)) && (new_y <= PYW'(ROW_HI));
    req_c   = 1'b0;
    tgt_c   = TERM_0;
    if (row_hit) begin
      priority if (new_x >= PXW'(TERM0_LO) && new_x <= PXW'(TERM0_HI)) begin
        req_c = 1'b1;
        tgt_c = TERM_0;
      end else if (new_x >= PXW'(TERM1_LO) && new_x <= PXW'(TERM1_HI)) begin
        req_c = 1'b1;
        tgt_c = TERM_1;
      end else if (new_x >= PXW'(TERM2_LO) && new_x <= PXW'(TERM2_HI)) begin
        req_c = 1'b1;
        tgt_c = TERM_2;
      end else begin
        req_c = 1'b0;
      end
    end
    new_x_ext = XS_W'(new_x);
    old_x_ext = XS_W'(pos_x_r);
    new_y_ext = YS_W'(new_y);
    old_y_ext = YS_W'(pos_y_r);
  end

  always_comb begin
    header_nxt = header_r;
    dx_nxt     = dx_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    if (s1_adv) begin
      unique case (phase_r)
        PH_DX: begin
          dx_nxt = s1_byte_r;
        end
        PH_DY: begin
          pos_x_nxt = new_x;
          pos_y_nxt = new_y;
        end
        default: begin
          if (hdr_ok) begin
            header_nxt = s1_byte_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_HEADER;
      header_r    <= '0;
      dx_r        <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      dx_r     <= dx_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      if (s1_adv && s1_result) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_data_byte;
    end
    if (s1_adv && s1_result) begin
      cur_x_r  <= new_x_ext[CURSOR_X_W-1:0];
      cur_y_r  <= new_y_ext[CURSOR_Y_W-1:0];
      prev_x_r <= old_x_ext[CURSOR_X_W-1:0];
      prev_y_r <= old_y_ext[CURSOR_Y_W-1:0];
      moved_r  <= (new_x != pos_x_r) || (new_y != pos_y_r);
      left_r   <= header_r[HDR_LEFT];
      req_r    <= req_c;
      tgt_r    <= tgt_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_x       = cur_x_r;
  assign out_cursor_y       = cur_y_r;
  assign out_prev_x         = prev_x_r;
  assign out_prev_y         = prev_y_r;
  assign out_moved          = moved_r;
  assign out_left_pressed   = left_r;
  assign out_switch_request = req_r;
  assign out_switch_target  = tgt_r;

endmodule

FILE: src/mpct_checker.sv
// ----------------------------------------------------------------------------
// mpct_checker
// Port-level checks on the mouse packet cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mpct_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [mpct_pkg::DATA_W-1:0]     in_data_byte,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [mpct_pkg::CURSOR_X_W-1:0] out_cursor_x,
  input logic [mpct_pkg::CURSOR_Y_W-1:0] out_cursor_y,
  input logic [mpct_pkg::CURSOR_X_W-1:0] out_prev_x,
  input logic [mpct_pkg::CURSOR_Y_W-1:0] out_prev_y,
  input logic                            out_moved,
  input logic                            out_left_pressed,
  input logic                            out_switch_request,
  input logic [mpct_pkg::TARGET_W-1:0]   out_switch_target
);
  import mpct_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_x) && $stable(out_cursor_y)
      && $stable(out_switch_request))
    else $error("stalled result changed");

  a_moved_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_moved == ((out_cursor_x != out_prev_x) || (out_cursor_y != out_prev_y)))
    else $error("moved flag inconsistent with positions");

  a_switch_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_request |-> out_left_pressed
      && out_cursor_y >= CURSOR_Y_W'(ROW_LO) && out_cursor_y <= CURSOR_Y_W'(ROW_HI))
    else $error("switch request outside terminal rows or without left button");

  a_switch_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_switch_request |-> out_switch_target == TERM_0)
    else $error("switch target set without a request");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (.*);
